### rtl/circular_deque_macros.svh
`ifndef CIRCULAR_DEQUE_MACROS_SVH
`define CIRCULAR_DEQUE_MACROS_SVH

// check that holds in the same cycle
`define CDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// check that holds in the cycle after the trigger
`define CDQ_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) trig |=> prop) \
      else $error(msg);

`endif

### rtl/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH    = 64;
   localparam int ELEM_W   = 8;
   localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;

   typedef logic [PTR_W-1:0]  ptr_type;
   typedef logic [ELEM_W-1:0] elem_type;

   localparam ptr_type PTR_LAST = PTR_W'(DEPTH - 1);

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_REAR  = 3'd0,
      FN_PUSH_FRONT = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_REAR   = 3'd3,
      FN_PEEK_FRONT = 3'd4,
      FN_PEEK_REAR  = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // controller to ring: write at the ring port
   typedef struct packed {
      logic     wr_en;
      elem_type wr_data;
   } ring_ctl_type;

   // ring to controller: slot passing the port and its data
   typedef struct packed {
      ptr_type  port_ptr;
      elem_type port_data;
   } ring_stat_type;

   function automatic ptr_type ptr_next(ptr_type p);
      return (p == PTR_LAST) ? '0 : ptr_type'(p + 1'b1);
   endfunction

   function automatic ptr_type ptr_prev(ptr_type p);
      return (p == '0) ? PTR_LAST : ptr_type'(p - 1'b1);
   endfunction

endpackage

### rtl/cdq_req_if.sv
interface cdq_req_if import cdq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   elem_type          item;

   modport source (output valid, output func, output item, input ready);
   modport sink   (input valid, input func, input item, output ready);
endinterface

### rtl/cdq_rsp_if.sv
interface cdq_rsp_if import cdq_pkg::*; ();
   logic                valid;
   logic                ready;
   elem_type            read_byte;
   logic [STATUS_W-1:0] status;
   logic                now_empty;
   logic                now_full;

   modport source (output valid, output read_byte, output status, output now_empty,
                   output now_full, input ready);
   modport sink   (input valid, input read_byte, input status, input now_empty,
                   input now_full, output ready);
endinterface

### rtl/circular_deque.sv
// a rejected or unused request gives its result in the cycle after it is taken;
// a push, pop or peek waits for its slot to turn past the ring port
// one request at a time: a new one is taken only once the last is done, as set by the
// rotation of the DEPTH-cell ring past its single access port
// reset: synchronous, active high; clears pointers and handshake state, slot data is
// left as is and is only read after it was written
module circular_deque import cdq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req_ch,
   cdq_rsp_if.source rsp_ch
);

   ring_ctl_type  ring_ctl;
   ring_stat_type ring_stat;

   cdq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .stat   (ring_stat),
      .ctl    (ring_ctl)
   );

   cdq_ring u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .stat  (ring_stat)
   );

endmodule

### rtl/cdq_cell.sv
module cdq_cell import cdq_pkg::*; (
   input  logic     clock,
   input  elem_type shift_in,
   input  logic     load_en,
   input  elem_type load_data,
   output elem_type data_out
);

   elem_type data_ff;
   elem_type data_in;

   always_comb begin
      data_in = load_en ? load_data : shift_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### rtl/cdq_ring.sv
module cdq_ring import cdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctl_type  ctl,
   output ring_stat_type stat
);

   elem_type chain [DEPTH];
   ptr_type  port_ptr_ff;
   ptr_type  port_ptr_in;

   // the ring turns every cycle; the last cell feeds the first through the port
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_port
         cdq_cell u_cell (
            .clock     (clock),
            .shift_in  (chain[DEPTH-1]),
            .load_en   (ctl.wr_en),
            .load_data (ctl.wr_data),
            .data_out  (chain[i])
         );
      end else begin : g_link
         cdq_cell u_cell (
            .clock     (clock),
            .shift_in  (chain[i-1]),
            .load_en   (1'b0),
            .load_data ('0),
            .data_out  (chain[i])
         );
      end
   end

   // slot held by the last cell steps back by one as the ring turns
   always_comb begin
      port_ptr_in = ptr_prev(port_ptr_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ptr_ff <= '0;
      end else begin
         port_ptr_ff <= port_ptr_in;
      end
   end

   assign stat.port_ptr  = port_ptr_ff;
   assign stat.port_data = chain[DEPTH-1];

endmodule

### rtl/cdq_ctrl.sv
module cdq_ctrl import cdq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   cdq_req_if.sink       req_ch,
   cdq_rsp_if.source     rsp_ch,
   input  ring_stat_type stat,
   output ring_ctl_type  ctl
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SEEK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   ptr_type   head_ff, head_in;
   ptr_type   tail_ff, tail_in;
   ptr_type   target_ff, target_in;
   logic      wr_ff, wr_in;
   elem_type  wdata_ff, wdata_in;

   logic                rsp_valid_ff, rsp_valid_in;
   elem_type            rsp_byte_ff, rsp_byte_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_empty_ff, rsp_empty_in;
   logic                rsp_full_ff, rsp_full_in;

   logic accept;
   logic hit;
   logic no_entries;
   logic is_full;
   logic access;

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign no_entries   = (head_ff == tail_ff);
   assign is_full      = (ptr_next(tail_ff) == head_ff);
   assign hit          = (state_ff == S_SEEK) && (stat.port_ptr == target_ff);

   assign ctl.wr_en   = hit && wr_ff;
   assign ctl.wr_data = wdata_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      target_in     = target_ff;
      wr_in         = wr_ff;
      wdata_in      = wdata_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      access        = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_status_in = ST_OK;
         wr_in         = 1'b0;
         case (func_type'(req_ch.func))
            FN_PUSH_REAR: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  access    = 1'b1;
                  wr_in     = 1'b1;
                  target_in = ptr_next(tail_ff);
                  tail_in   = ptr_next(tail_ff);
               end
            end
            FN_PUSH_FRONT: begin
               if (is_full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  access    = 1'b1;
                  wr_in     = 1'b1;
                  target_in = head_ff;
                  head_in   = ptr_prev(head_ff);
               end
            end
            FN_POP_FRONT: begin
               if (no_entries) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  access    = 1'b1;
                  target_in = ptr_next(head_ff);
                  head_in   = ptr_next(head_ff);
               end
            end
            FN_POP_REAR: begin
               if (no_entries) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  access    = 1'b1;
                  target_in = tail_ff;
                  tail_in   = ptr_prev(tail_ff);
               end
            end
            FN_PEEK_FRONT: begin
               if (no_entries) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  access    = 1'b1;
                  target_in = ptr_next(head_ff);
               end
            end
            FN_PEEK_REAR: begin
               if (no_entries) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  access    = 1'b1;
                  target_in = tail_ff;
               end
            end
            default: begin
            end
         endcase

         // flags reflect the pointers after this item
         wdata_in     = req_ch.item;
         rsp_byte_in  = '0;
         rsp_empty_in = (head_in == tail_in);
         rsp_full_in  = (ptr_next(tail_in) == head_in);
         if (access) begin
            state_in = S_SEEK;
         end else begin
            rsp_valid_in = 1'b1;
         end
      end

      // wait until the target slot passes the ring port
      if (hit) begin
         state_in     = S_IDLE;
         rsp_valid_in = 1'b1;
         if (!wr_ff) begin
            rsp_byte_in = stat.port_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff     <= target_in;
      wr_ff         <= wr_in;
      wdata_ff      <= wdata_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_byte = rsp_byte_ff;
   assign rsp_ch.status    = rsp_status_ff;
   assign rsp_ch.now_empty = rsp_empty_ff;
   assign rsp_ch.now_full  = rsp_full_ff;

endmodule

### rtl/circular_deque_checker.sv
`include "circular_deque_macros.svh"

module circular_deque_checker import cdq_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input elem_type            rsp_read_byte,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_now_empty,
   input logic                rsp_now_full
);

   `CDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

   // only one item in flight: a new one is taken only when the result slot frees
   `CDQ_ASSERT(a_one_inflight, req_valid && req_ready |-> !rsp_valid || rsp_ready, "item taken over a pending result")

   `CDQ_ASSERT(a_reject_zero, rsp_valid && rsp_status != ST_OK |-> rsp_read_byte == '0, "rejected item returned data")

   `CDQ_ASSERT(a_full_flag, rsp_valid && rsp_status == ST_FULL |-> rsp_now_full && !rsp_now_empty, "full reject without full flag")

   `CDQ_ASSERT(a_empty_flag, rsp_valid && rsp_status == ST_EMPTY |-> rsp_now_empty && !rsp_now_full, "empty reject without empty flag")

endmodule

bind circular_deque circular_deque_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_read_byte (rsp_ch.read_byte),
   .rsp_status    (rsp_ch.status),
   .rsp_now_empty (rsp_ch.now_empty),
   .rsp_now_full  (rsp_ch.now_full)
);
